FILE: hw/rtl/lwc_pkg.sv
// lwc_pkg: shared constants and register map of the line window clipper
// no dependencies
package lwc_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int MAX_PASSES     = 16;
	localparam int PASS_W         = $clog2(MAX_PASSES + 1);

	typedef enum logic [2:0] {
		REG_VIEW_LEFT    = 3'd0,
		REG_VIEW_RIGHT   = 3'd1,
		REG_VIEW_BOTTOM  = 3'd2,
		REG_VIEW_TOP     = 3'd3,
		REG_WORLD_LEFT   = 3'd4,
		REG_WORLD_RIGHT  = 3'd5,
		REG_WORLD_BOTTOM = 3'd6,
		REG_WORLD_TOP    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic empty;
	} win_stat_t;
endpackage

FILE: hw/rtl/line_window_clipper.sv
// line_window_clipper: top level, config registers and stream ports
// depends on lwc_pkg, lwc_front, lwc_queue, lwc_engine
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     start_x, start_y, end_x, end_y
// m_*       out  tvalid/tready     out_start_x .. out_end_y, visible in tuser
// apb       in   psel/penable      eight window registers
//
// from its pop an item passes ST_TEST and then, for each edge crossing, a serial
// multiply (ST_MUL) and a restoring divide (ST_DIV) before ST_WRITE; a vertical
// snap goes straight back to ST_TEST; trivial accept or reject goes to ST_FIN,
// and an empty window goes from ST_IDLE straight to ST_FIN
// reset clears registers, queue and engine; no clearing pass
// the queue holds two items, taken while the engine works or a result waits on m_tready
module line_window_clipper import lwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int DW = (COORD_BITS > 32) ? 64 : 32,
	localparam int AW = (COORD_BITS > 32) ? 6 : 5,
	localparam int TW = ((4 * COORD_BITS + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	// slave stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [TW-1:0] s_tdata,  // start_x, start_y, end_x, end_y
	// master stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [TW-1:0] m_tdata,  // out_start_x, out_start_y, out_end_x, out_end_y
	output logic          m_tuser,  // visible
	// config port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready
);
	localparam int W = COORD_BITS;

	logic signed [W-1:0] regs_q [8];
	reg_idx_t idx;
	logic q_push, q_full, q_pop, q_valid, out_vis;
	logic [4*W-1:0] q_in, q_out, out_data;
	logic signed [W-1:0] win_l, win_r, win_b, win_t;
	win_stat_t win_stat;

	assign pready = 1'b1;
	// register index from the word address
	assign idx = reg_idx_t'(paddr[AW-1:AW-3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata[W-1:0];
		end
	end

	// reads return the register sign-extended to the bus
	always_comb begin
		case (idx)
			REG_VIEW_LEFT:    prdata = DW'(regs_q[REG_VIEW_LEFT]);
			REG_VIEW_RIGHT:   prdata = DW'(regs_q[REG_VIEW_RIGHT]);
			REG_VIEW_BOTTOM:  prdata = DW'(regs_q[REG_VIEW_BOTTOM]);
			REG_VIEW_TOP:     prdata = DW'(regs_q[REG_VIEW_TOP]);
			REG_WORLD_LEFT:   prdata = DW'(regs_q[REG_WORLD_LEFT]);
			REG_WORLD_RIGHT:  prdata = DW'(regs_q[REG_WORLD_RIGHT]);
			REG_WORLD_BOTTOM: prdata = DW'(regs_q[REG_WORLD_BOTTOM]);
			REG_WORLD_TOP:    prdata = DW'(regs_q[REG_WORLD_TOP]);
			default:          prdata = '0;
		endcase
	end

	lwc_front #(.COORD_BITS(W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.view_left(regs_q[REG_VIEW_LEFT]), .view_right(regs_q[REG_VIEW_RIGHT]),
		.view_bottom(regs_q[REG_VIEW_BOTTOM]), .view_top(regs_q[REG_VIEW_TOP]),
		.world_left(regs_q[REG_WORLD_LEFT]), .world_right(regs_q[REG_WORLD_RIGHT]),
		.world_bottom(regs_q[REG_WORLD_BOTTOM]), .world_top(regs_q[REG_WORLD_TOP]),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[4*W-1:0]),
		.q_full(q_full), .q_push(q_push), .q_data(q_in),
		.win_l(win_l), .win_r(win_r), .win_b(win_b), .win_t(win_t),
		.win_stat(win_stat)
	);

	lwc_queue #(.WIDTH(4 * W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .valid(q_valid), .pop_data(q_out)
	);

	lwc_engine #(.COORD_BITS(W)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_out),
		.win_l(win_l), .win_r(win_r), .win_b(win_b), .win_t(win_t),
		.win_stat(win_stat),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_data(out_data), .out_vis(out_vis)
	);

	assign m_tdata = TW'(out_data);
	assign m_tuser = out_vis;
endmodule

FILE: hw/rtl/lwc_front.sv
// lwc_front: takes segment items into the queue and derives the clip window
// depends on lwc_pkg
module lwc_front import lwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COORD_BITS-1:0] view_left,
	input  logic signed [COORD_BITS-1:0] view_right,
	input  logic signed [COORD_BITS-1:0] view_bottom,
	input  logic signed [COORD_BITS-1:0] view_top,
	input  logic signed [COORD_BITS-1:0] world_left,
	input  logic signed [COORD_BITS-1:0] world_right,
	input  logic signed [COORD_BITS-1:0] world_bottom,
	input  logic signed [COORD_BITS-1:0] world_top,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [4*COORD_BITS-1:0]      in_data,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [4*COORD_BITS-1:0]      q_data,
	output logic signed [COORD_BITS-1:0] win_l,
	output logic signed [COORD_BITS-1:0] win_r,
	output logic signed [COORD_BITS-1:0] win_b,
	output logic signed [COORD_BITS-1:0] win_t,
	output win_stat_t                    win_stat
);
	logic signed [COORD_BITS-1:0] l_q, r_q, b_q, t_q;
	win_stat_t stat_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_data   = in_data;

	// window is the overlap of the two rectangles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q <= '0;
			r_q <= '0;
			b_q <= '0;
			t_q <= '0;
			stat_q <= '0;
		end else begin
			l_q <= (view_left > world_left) ? view_left : world_left;
			r_q <= (view_right < world_right) ? view_right : world_right;
			b_q <= (view_bottom > world_bottom) ? view_bottom : world_bottom;
			t_q <= (view_top < world_top) ? view_top : world_top;
			stat_q.empty <= ((view_left > world_left) ? view_left : world_left) >
				((view_right < world_right) ? view_right : world_right) ||
				((view_bottom > world_bottom) ? view_bottom : world_bottom) >
				((view_top < world_top) ? view_top : world_top);
		end
	end

	assign win_l    = l_q;
	assign win_r    = r_q;
	assign win_b    = b_q;
	assign win_t    = t_q;
	assign win_stat = stat_q;
endmodule

FILE: hw/rtl/lwc_queue.sv
// lwc_queue: two-entry queue between front and clip engine
// depends on lwc_pkg
module lwc_queue import lwc_pkg::*; #(
	parameter int WIDTH = 4 * COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	assign full     = cnt_q == 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];
endmodule

FILE: hw/rtl/lwc_engine.sv
// lwc_engine: outcode passes, serial multiply and restoring divide, result register
// depends on lwc_pkg
module lwc_engine import lwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic [4*COORD_BITS-1:0]      q_data,
	input  logic signed [COORD_BITS-1:0] win_l,
	input  logic signed [COORD_BITS-1:0] win_r,
	input  logic signed [COORD_BITS-1:0] win_b,
	input  logic signed [COORD_BITS-1:0] win_t,
	input  win_stat_t                    win_stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [4*COORD_BITS-1:0]      out_data,
	output logic                         out_vis
);
	localparam int W  = COORD_BITS;
	localparam int D  = W + 1;
	localparam int P  = 2 * D;
	localparam int CW = $clog2(P + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_TEST, ST_MUL, ST_DIV, ST_WRITE, ST_FIN} state_t;

	state_t state_q;
	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q, base_q, edge_q;
	logic [PASS_W-1:0] pass_q;
	logic [P-1:0] mcand_q, prod_q;
	logic [D-1:0] mplier_q, den_q, rem_q;
	logic [D:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, tgt_y_q, vis_q;
	logic out_valid_q, out_vis_q;
	logic [4*W-1:0] out_data_q;

	// outcodes: bit0 left, bit1 right, bit2 bottom, bit3 top
	logic [3:0] c1, c2, ca;
	logic swap;
	logic signed [W-1:0] ax, ay, bx, by;
	logic signed [D-1:0] dx, dy, num, dnum, den;
	logic [D-1:0] m_num, m_dnum, m_den;
	logic [D:0] div_t;
	logic signed [D+1:0] sum;

	always_comb begin
		c1 = {y1_q > win_t, y1_q < win_b, x1_q > win_r, x1_q < win_l};
		c2 = {y2_q > win_t, y2_q < win_b, x2_q > win_r, x2_q < win_l};
		swap = c1 == 4'd0;
		ax = swap ? x2_q : x1_q;
		ay = swap ? y2_q : y1_q;
		bx = swap ? x1_q : x2_q;
		by = swap ? y1_q : y2_q;
		ca = swap ? c2 : c1;
		dx = {bx[W-1], bx} - {ax[W-1], ax};
		dy = {by[W-1], by} - {ay[W-1], ay};
		if (ca[0]) begin
			num = {win_l[W-1], win_l} - {ax[W-1], ax};
			dnum = dy;
			den = dx;
		end else if (ca[1]) begin
			num = {win_r[W-1], win_r} - {ax[W-1], ax};
			dnum = dy;
			den = dx;
		end else if (ca[2]) begin
			num = {win_b[W-1], win_b} - {ay[W-1], ay};
			dnum = dx;
			den = dy;
		end else begin
			num = {win_t[W-1], win_t} - {ay[W-1], ay};
			dnum = dx;
			den = dy;
		end
		m_num  = num[D-1] ? -num : num;
		m_dnum = dnum[D-1] ? -dnum : dnum;
		m_den  = den[D-1] ? -den : den;
		div_t  = {rem_q, prod_q[P-1]};
		sum = neg_q ? {{3{base_q[W-1]}}, base_q} - {1'b0, quo_q}
			: {{3{base_q[W-1]}}, base_q} + {1'b0, quo_q};
	end

	assign q_pop = q_valid && state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			pass_q <= '0;
			cnt_q <= '0;
			vis_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						x1_q <= q_data[W-1:0];
						y1_q <= q_data[2*W-1:W];
						x2_q <= q_data[3*W-1:2*W];
						y2_q <= q_data[4*W-1:3*W];
						pass_q <= '0;
						vis_q <= 1'b0;
						state_q <= win_stat.empty ? ST_FIN : ST_TEST;
					end
				end
				ST_TEST: begin
					if (pass_q == PASS_W'(MAX_PASSES)) begin
						state_q <= ST_FIN;
					end else if (c1 == 4'd0 && c2 == 4'd0) begin
						vis_q <= 1'b1;
						state_q <= ST_FIN;
					end else if ((c1 & c2) != 4'd0) begin
						state_q <= ST_FIN;
					end else begin
						x1_q <= ax;
						x2_q <= bx;
						y2_q <= by;
						if (ax == bx) begin
							// vertical segment: snap y onto the edge
							y1_q <= ca[3] ? win_t : ca[2] ? win_b : ay;
							pass_q <= pass_q + 1'b1;
						end else begin
							y1_q <= ay;
							tgt_y_q <= ca[0] || ca[1];
							base_q <= (ca[0] || ca[1]) ? ay : ax;
							edge_q <= ca[0] ? win_l : ca[1] ? win_r : ca[2] ? win_b : win_t;
							neg_q <= num[D-1] ^ dnum[D-1] ^ den[D-1];
							mcand_q <= {{D{1'b0}}, m_num};
							mplier_q <= m_dnum;
							den_q <= m_den;
							prod_q <= '0;
							cnt_q <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// one multiplier bit a cycle
					if (mplier_q[0])
						prod_q <= prod_q + mcand_q;
					mcand_q <= {mcand_q[P-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[D-1:1]};
					rem_q <= '0;
					quo_q <= '0;
					if (cnt_q == CW'(D - 1)) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// restoring divide, one quotient bit a cycle
					if (div_t >= {1'b0, den_q}) begin
						rem_q <= D'(div_t - {1'b0, den_q});
						quo_q <= {quo_q[D-1:0], 1'b1};
					end else begin
						rem_q <= div_t[D-1:0];
						quo_q <= {quo_q[D-1:0], 1'b0};
					end
					prod_q <= {prod_q[P-2:0], 1'b0};
					if (cnt_q == CW'(P - 1)) begin
						cnt_q <= '0;
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (tgt_y_q) begin
						y1_q <= (den_q == '0) ? base_q : sum[W-1:0];
						x1_q <= edge_q;
					end else begin
						x1_q <= (den_q == '0) ? base_q : sum[W-1:0];
						y1_q <= edge_q;
					end
					pass_q <= pass_q + 1'b1;
					state_q <= ST_TEST;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_vis_q <= vis_q;
						out_data_q <= {y2_q, x2_q, y1_q, x1_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_vis   = out_vis_q;

`ifndef SYNTHESIS
	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= PASS_W'(MAX_PASSES))
		else $error("pass count beyond bound");
	a_vis_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && vis_q |-> c1 == 4'd0 && c2 == 4'd0)
		else $error("visible segment with an endpoint outside");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && $past(state_q) == ST_TEST |-> cnt_q == '0)
		else $error("multiply started with stale count");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_TEST || state_q == ST_FIN)
		else $error("item popped without starting work");
`endif
endmodule

FILE: bench/testbench.sv
// testbench: stream and apb bench for line_window_clipper
// depends on lwc_pkg and line_window_clipper; self-contained predictor
`timescale 1ns / 100ps

module testbench import lwc_pkg::*; ();

	localparam int TW = 128;
	localparam int AW = 5;
	localparam int N_RANDOM = 1900;
	localparam longint CYCLE_LIMIT = 64'd10000000;

	typedef struct packed {
		logic signed [31:0] ey;
		logic signed [31:0] ex;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
	} segment_t;

	typedef struct {
		logic          vis;
		logic [TW-1:0] pts;
	} clip_result_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [TW-1:0] s_tdata;   // start_x, start_y, end_x, end_y
	logic          m_tvalid;
	logic          m_tready;
	logic [TW-1:0] m_tdata;   // out_start_x, out_start_y, out_end_x, out_end_y
	logic          m_tuser;   // visible
	logic          psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	line_window_clipper DUT (.*);

	// window registers as the bench believes them
	logic signed [31:0] win_reg [8];

	segment_t     pending_segs [$];
	clip_result_t expected_clips [$];
	int           mismatches;
	int           sent;
	int           m_count;
	longint       cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// base + trunc(num * dnum / den), wide exact
	function automatic logic signed [63:0] crossing(logic signed [63:0] base,
			logic signed [63:0] num, logic signed [63:0] dnum,
			logic signed [63:0] den);
		logic signed [127:0] prod;
		logic signed [127:0] q;
		if (den == 0) return base;
		prod = 128'(num) * 128'(dnum);
		q = prod / 128'(den);   // sv signed division truncates toward zero
		return base + 64'(q);
	endfunction

	function automatic logic [3:0] region(logic signed [63:0] x, logic signed [63:0] y,
			logic signed [63:0] l, logic signed [63:0] r,
			logic signed [63:0] b, logic signed [63:0] t);
		region = {y > t, y < b, x > r, x < l};
	endfunction

	function automatic clip_result_t clip_segment(segment_t s);
		logic signed [63:0] l, r, b, t, x1, y1, x2, y2, tmp;
		logic [3:0] c1, c2, tc;
		clip_result_t res;
		l = (win_reg[REG_VIEW_LEFT] > win_reg[REG_WORLD_LEFT]) ?
			win_reg[REG_VIEW_LEFT] : win_reg[REG_WORLD_LEFT];
		r = (win_reg[REG_VIEW_RIGHT] < win_reg[REG_WORLD_RIGHT]) ?
			win_reg[REG_VIEW_RIGHT] : win_reg[REG_WORLD_RIGHT];
		b = (win_reg[REG_VIEW_BOTTOM] > win_reg[REG_WORLD_BOTTOM]) ?
			win_reg[REG_VIEW_BOTTOM] : win_reg[REG_WORLD_BOTTOM];
		t = (win_reg[REG_VIEW_TOP] < win_reg[REG_WORLD_TOP]) ?
			win_reg[REG_VIEW_TOP] : win_reg[REG_WORLD_TOP];
		x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
		res.vis = 1'b0;
		if (l <= r && b <= t) begin
			for (int p = 0; p < MAX_PASSES; p++) begin
				c1 = region(x1, y1, l, r, b, t);
				c2 = region(x2, y2, l, r, b, t);
				if (c1 == 0 && c2 == 0) begin
					res.vis = 1'b1;
					break;
				end
				if ((c1 & c2) != 0) break;
				if (c1 == 0) begin
					tmp = x1; x1 = x2; x2 = tmp;
					tmp = y1; y1 = y2; y2 = tmp;
					tc = c1; c1 = c2; c2 = tc;
				end
				if (x1 == x2) begin
					if (c1[3]) y1 = t;
					else if (c1[2]) y1 = b;
				end else if (c1[0]) begin
					y1 = crossing(y1, l - x1, y2 - y1, x2 - x1);
					x1 = l;
				end else if (c1[1]) begin
					y1 = crossing(y1, r - x1, y2 - y1, x2 - x1);
					x1 = r;
				end else if (c1[2]) begin
					x1 = crossing(x1, b - y1, x2 - x1, y2 - y1);
					y1 = b;
				end else if (c1[3]) begin
					x1 = crossing(x1, t - y1, x2 - x1, y2 - y1);
					y1 = t;
				end
			end
		end
		res.pts = {y2[31:0], x2[31:0], y1[31:0], x1[31:0]};
		return res;
	endfunction

	// driver: idle gap drawn per item, valid held until accepted
	int s_gap;
	int s_issued;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_gap    <= 0;
			s_issued <= 0;
		end else if (s_tvalid && sent != s_issued) begin
			// hold the item until it is taken
		end else if (s_gap > 0) begin
			s_tvalid <= 1'b0;
			s_gap    <= s_gap - 1;
		end else if (pending_segs.size() > 0) begin
			s_tdata  <= pending_segs.pop_front();
			s_tvalid <= 1'b1;
			s_issued <= s_issued + 1;
			s_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// prediction on acceptance
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_clips.insert(expected_clips.size(), clip_segment(segment_t'(s_tdata)));
			sent <= sent + 1;
		end
	end

	// receiver stall pattern, a wait drawn after each taken result
	int m_gap;
	int m_seen;
	int m_draw;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap    <= 0;
			m_seen   <= 0;
		end else if (m_seen != m_count) begin
			m_seen   <= m_count;
			m_draw   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			m_gap    <= (m_draw > 0) ? m_draw - 1 : 0;
			m_tready <= (m_draw == 0);
		end else if (m_gap > 0) begin
			m_tready <= 1'b0;
			m_gap    <= m_gap - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		clip_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			m_count <= m_count + 1;
			if (expected_clips.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result vis=%0b pts=%h", m_tuser, m_tdata);
			end else begin
				want = expected_clips.pop_front();
				if (want.vis !== m_tuser || want.pts !== m_tdata) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("clip mismatch: want vis=%0b %h got vis=%0b %h",
							want.vis, want.pts, m_tuser, m_tdata);
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic signed [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= AW'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		win_reg[idx] = val;
	endtask

	task automatic set_window(logic signed [31:0] vl, vr, vb, vt, wl, wr, wb, wt);
		reg_write(REG_VIEW_LEFT, vl);   reg_write(REG_VIEW_RIGHT, vr);
		reg_write(REG_VIEW_BOTTOM, vb); reg_write(REG_VIEW_TOP, vt);
		reg_write(REG_WORLD_LEFT, wl);  reg_write(REG_WORLD_RIGHT, wr);
		reg_write(REG_WORLD_BOTTOM, wb); reg_write(REG_WORLD_TOP, wt);
	endtask

	// wait until every queued segment went in and every result came out
	task automatic drain;
		wait (pending_segs.size() == 0 && !s_tvalid);
		wait (expected_clips.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// coordinate near a window, sometimes extreme, sometimes on an edge
	function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo,
			logic signed [31:0] hi);
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return lo;
			3: return hi;
			4: return $urandom;
			default: return lo + $signed($urandom_range(0, 32'h0030_0000)) - 32'sh0008_0000
				+ ((hi - lo) >>> 1) * $signed($urandom_range(0, 2)) ;
		endcase
	endfunction

	task automatic random_segments(int n, logic signed [31:0] lo, logic signed [31:0] hi);
		segment_t s;
		for (int i = 0; i < n; i++) begin
			s.sx = pick_coord(lo, hi); s.sy = pick_coord(lo, hi);
			s.ex = pick_coord(lo, hi); s.ey = pick_coord(lo, hi);
			case ($urandom_range(0, 7))
				0: s.ex = s.sx;          // vertical
				1: s.ey = s.sy;          // horizontal
				2: begin s.ex = s.sx; s.ey = s.sy; end
				default: ;
			endcase
			pending_segs.insert(pending_segs.size(), s);
		end
	endtask

	initial begin
		segment_t d;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cycles = 0; mismatches = 0; sent = 0; m_count = 0;
		for (int i = 0; i < 8; i++) win_reg[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset window is the single point at the origin
		pending_segs.insert(pending_segs.size(),
			segment_t'({32'sh0, 32'sh0, 32'sh0, 32'sh0}));
		pending_segs.insert(pending_segs.size(),
			segment_t'({32'sh10000, 32'sh10000, -32'sh10000, -32'sh10000}));
		drain();

		// directed: views -10..10 in both axes, world wider but for its bottom at -8
		set_window(-32'sh000a_0000, 32'sh000a_0000, -32'sh000a_0000, 32'sh000a_0000,
			-32'sh0014_0000, 32'sh0014_0000, -32'sh0008_0000, 32'sh0014_0000);
		d = '{ey: 32'sh1_0000, ex: 32'sh2_0000, sy: 32'sh0, sx: 32'sh0};  // inside
		pending_segs.insert(pending_segs.size(), d);
		d = '{ey: 32'sh1_0000, ex: 32'sh0, sy: 32'sh7fff_ffff, sx: 32'sh0}; // vertical top
		pending_segs.insert(pending_segs.size(), d);
		d = '{ey: 32'sh8000_0000, ex: 32'sh1_0000, sy: 32'sh0, sx: 32'sh1_0000}; // vertical bottom
		pending_segs.insert(pending_segs.size(), d);
		d = '{ey: 32'sh0, ex: 32'sh7fff_ffff, sy: 32'sh0, sx: 32'sh8000_0000}; // left and right
		pending_segs.insert(pending_segs.size(), d);
		d = '{ey: 32'sh7fff_ffff, ex: 32'sh7fff_ffff, sy: 32'sh8000_0000, sx: 32'sh8000_0000};
		pending_segs.insert(pending_segs.size(), d); // crosses the left, bottom and right edges
		d = '{ey: 32'sh0030_0000, ex: 32'sh0030_0000, sy: 32'sh0020_0000, sx: 32'sh0020_0000};
		pending_segs.insert(pending_segs.size(), d); // trivial reject
		d = '{ey: -32'sh0008_0000, ex: 32'sh000a_0000, sy: 32'sh000a_0000, sx: -32'sh000a_0000};
		pending_segs.insert(pending_segs.size(), d); // corners on the edges
		d = '{ey: 32'sh0050_0000, ex: 32'sh0050_0000, sy: 32'sh0, sx: 32'sh0}; // start inside, swap
		pending_segs.insert(pending_segs.size(), d);
		d = '{ey: 32'sh0050_0000, ex: -32'sh0040_0000, sy: -32'sh0050_0000, sx: 32'sh0013_0000};
		pending_segs.insert(pending_segs.size(), d); // misses a corner, rejected after clipping
		d = '{ey: 32'sh1234_5678, ex: 32'shedcb_a987, sy: 32'sh5555_5555, sx: 32'shaaaa_aaaa};
		pending_segs.insert(pending_segs.size(), d);
		drain();

		// empty window: inputs come back untouched
		set_window(32'sh0010_0000, -32'sh0010_0000, 32'sh0, 32'sh0010_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		random_segments(40, -32'sh0010_0000, 32'sh0010_0000);
		drain();

		// widest window
		set_window(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		random_segments(120, 32'sh8000_0000, 32'sh7fff_ffff);
		drain();

		// several random windows
		for (int w = 0; w < 8; w++) begin
			logic signed [31:0] c, h;
			c = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			h = $urandom_range(0, 32'h0040_0000);
			set_window(c - h, c + h, c - h, c + h,
				c - h + $signed($urandom_range(0, 32'h8_0000)), $urandom,
				$urandom % 2 ? 32'sh8000_0000 : c - h,
				c + h - $signed($urandom_range(0, 32'h8_0000)));
			random_segments((N_RANDOM - 160) / 8, c - 2 * h, c + 2 * h);
			drain();
		end

		if (mismatches == 0 && expected_clips.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
